// ===== rtl/stir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table package
// Shared constants, operation and status codes, and the command broadcast
// from the control logic to every storage cell.
// ----------------------------------------------------------------------------
package stir_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int IN_IDX_W = 8;
    localparam int OUT_CNT_W = 9;

    typedef enum logic [2:0] {
        FUNC_INSERT    = 3'd0,
        FUNC_REMOVE    = 3'd1,
        FUNC_REMOVE_AT = 3'd2,
        FUNC_READ_AT   = 3'd3,
        FUNC_CONTAINS  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic                     ins;
        logic                     del_val;
        logic                     del_at;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ===== rtl/sorted_table_insert_remove_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table core
// The result beat is registered and appears in the cycle after start is taken.
// Throughput: one operation per cycle; busy stays low, every cell compares
// and shifts in the same cycle the command arrives.
// Reset clears the entry count and the result strobe; entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_core
    import stir_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  func,
    input  logic signed [DATA_W-1:0]    value,
    input  logic [IN_IDX_W-1:0]         index,
    output logic                        done,
    output logic signed [DATA_W-1:0]    result_value,
    output logic                        found,
    output logic [1:0]                  status,
    output logic [OUT_CNT_W-1:0]        entry_count
);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    logic signed [DATA_W-1:0] rv_reg;
    logic signed [DATA_W-1:0] rv_next;
    logic                     found_reg;
    logic                     found_next;
    status_t                  status_reg;
    status_t                  status_next;
    cell_cmd_t                cmd;

    logic signed [DATA_W-1:0] ent   [CAPACITY];
    logic [CAPACITY-1:0]      after;
    logic [CAPACITY-1:0]      eq;
    logic [CAPACITY-1:0]      valid;
    logic [CAPACITY-1:0]      idx_hit;
    logic                     any_eq;
    logic                     idx_bad;
    logic [OUT_CNT_W-1:0]     count_w;

    assign busy    = 1'b0;
    assign count_w = OUT_CNT_W'(count_reg);
    assign any_eq  = |eq;
    assign idx_bad = {1'b0, index} >= count_w;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign valid[g]   = OUT_CNT_W'(g) < count_w;
            assign idx_hit[g] = OUT_CNT_W'(g) >= {1'b0, index};

            stir_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .valid      (valid[g]),
                .found      (any_eq),
                .idx_hit    (idx_hit[g]),
                .after_in   ((g == 0) ? 1'b0 : after[(g == 0) ? 0 : g-1]),
                .left_data  ((g == 0) ? '0 : ent[(g == 0) ? 0 : g-1]),
                .right_data (ent[(g == CAPACITY-1) ? g : g+1]),
                .after_out  (after[g]),
                .eq         (eq[g]),
                .entry      (ent[g])
            );
        end
    endgenerate

    always_comb
    begin
        cmd         = '0;
        cmd.value   = value;
        count_next  = count_reg;
        rv_next     = '0;
        found_next  = 1'b0;
        status_next = STAT_OK;
        if (start)
        begin
            case (func)
                FUNC_INSERT:
                begin
                    if (count_w >= OUT_CNT_W'(CAPACITY))
                        status_next = STAT_FULL;
                    else
                    begin
                        cmd.ins    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_REMOVE:
                begin
                    if (count_reg == '0)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        cmd.del_val = 1'b1;
                        found_next  = any_eq;
                        if (any_eq)
                            count_next = count_reg - CNT_W'(1);
                    end
                end
                FUNC_REMOVE_AT:
                begin
                    if (idx_bad)
                        status_next = STAT_BAD_INDEX;
                    else
                    begin
                        cmd.del_at = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                FUNC_READ_AT:
                begin
                    if (idx_bad)
                        status_next = STAT_BAD_INDEX;
                    else
                        rv_next = ent[index[IDX_W-1:0]];
                end
                FUNC_CONTAINS:
                begin
                    found_next = any_eq;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg     <= rv_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign result_value = rv_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign entry_count  = count_w;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_w <= OUT_CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_beat_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("missing result beat");

    a_no_spurious_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> !done && $stable(count_reg))
        else $error("result beat or count change without start");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (start && func == FUNC_INSERT && count_w == OUT_CNT_W'(CAPACITY))
        |=> status == STAT_FULL && $stable(count_reg))
        else $error("insert into full table not dropped");

    a_found_only_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start && func != FUNC_REMOVE && func != FUNC_CONTAINS) |=> !found)
        else $error("found set on non-search operation");
`endif

endmodule

// ===== rtl/stir_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one entry, compares it against the broadcast value and takes data
// from its left or right neighbor to open or close a gap in the row, or the value to fill it.
// ----------------------------------------------------------------------------
module stir_cell
    import stir_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic                     valid,
    input  logic                     found,
    input  logic                     idx_hit,
    input  logic                     after_in,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic                     after_out,
    output logic                     eq,
    output logic signed [DATA_W-1:0] entry
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     less;

    assign less      = entry_reg < cmd.value;
    assign after_out = !valid || !less;
    assign eq        = valid && (entry_reg == cmd.value);
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (after_out)
                entry_next = after_in ? left_data : cmd.value;
        end
        else if (cmd.del_val && found && after_out)
            entry_next = right_data;
        else if (cmd.del_at && idx_hit)
            entry_next = right_data;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== dv/sorted_table_insert_remove_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table core testbench
// Sends insert, remove, remove-at, read-at and contains commands, with random
// gaps, and checks every result beat against a software copy of the table.
// A directed pass covers the empty table, a full table and the value
// extremes. A random pass then drifts the fill level between empty and full.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_core_tb;
    import stir_pkg::*;

    localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
    localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [DATA_W-1:0] rv;
        logic                     fnd;
        logic [1:0]               st;
        logic [OUT_CNT_W-1:0]     cnt;
    } table_reply_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [2:0]                  func = '0;
    logic signed [DATA_W-1:0]    value = '0;
    logic [IN_IDX_W-1:0]         index = '0;
    logic                        busy;
    logic                        done;
    logic signed [DATA_W-1:0]    result_value;
    logic                        found;
    logic [1:0]                  status;
    logic [OUT_CNT_W-1:0]        entry_count;

    logic signed [DATA_W-1:0]    tab_vals [CAPACITY];
    int                          tab_count;
    table_reply_t                reply_q [$];
    logic signed [DATA_W-1:0]    pool_vals [8];

    int  fail_count = 0;
    int  n_checked = 0;
    int  n_full = 0;
    int  n_bad_index = 0;
    int  n_found = 0;
    bit  gaps_on = 1'b1;

    sorted_table_insert_remove_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .value        (value),
        .index        (index),
        .done         (done),
        .result_value (result_value),
        .found        (found),
        .status       (status),
        .entry_count  (entry_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic void drop_entry(int pos);
        int k;
        for (k = pos; k + 1 < tab_count; k++)
            tab_vals[k] = tab_vals[k + 1];
        tab_count--;
    endfunction

    function automatic table_reply_t apply_table_op(logic [2:0] f,
                                                    logic signed [DATA_W-1:0] v,
                                                    logic [IN_IDX_W-1:0] ix);
        table_reply_t r;
        int pos;
        int k;
        r.rv  = '0;
        r.fnd = 1'b0;
        r.st  = STAT_OK;
        case (f)
            FUNC_INSERT:
            begin
                if (tab_count >= CAPACITY)
                    r.st = STAT_FULL;
                else
                begin
                    pos = 0;
                    while (pos < tab_count && tab_vals[pos] < v)
                        pos++;
                    for (k = tab_count; k > pos; k--)
                        tab_vals[k] = tab_vals[k - 1];
                    tab_vals[pos] = v;
                    tab_count++;
                end
            end
            FUNC_REMOVE:
            begin
                if (tab_count == 0)
                    r.st = STAT_EMPTY;
                else
                begin
                    for (k = 0; k < tab_count; k++)
                    begin
                        if (tab_vals[k] == v)
                        begin
                            drop_entry(k);
                            r.fnd = 1'b1;
                            break;
                        end
                    end
                end
            end
            FUNC_REMOVE_AT:
            begin
                if (int'(ix) >= tab_count)
                    r.st = STAT_BAD_INDEX;
                else
                    drop_entry(int'(ix));
            end
            FUNC_READ_AT:
            begin
                if (int'(ix) >= tab_count)
                    r.st = STAT_BAD_INDEX;
                else
                    r.rv = tab_vals[ix];
            end
            FUNC_CONTAINS:
            begin
                for (k = 0; k < tab_count; k++)
                begin
                    if (tab_vals[k] == v)
                    begin
                        r.fnd = 1'b1;
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = OUT_CNT_W'(tab_count);
        return r;
    endfunction

    // check the result beat first, then predict the command taken at this edge
    always @(posedge clk)
    begin
        table_reply_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_r = reply_q.pop_front();
                    n_checked++;
                    if (exp_r.st == STAT_FULL)
                        n_full++;
                    if (exp_r.st == STAT_BAD_INDEX)
                        n_bad_index++;
                    if (exp_r.fnd)
                        n_found++;
                    if (result_value !== exp_r.rv)
                    begin
                        $error("result_value: expected %0d, got %0d", exp_r.rv, result_value);
                        fail_count++;
                    end
                    if (found !== exp_r.fnd)
                    begin
                        $error("found: expected %0d, got %0d", exp_r.fnd, found);
                        fail_count++;
                    end
                    if (status !== exp_r.st)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.st, status);
                        fail_count++;
                    end
                    if (entry_count !== exp_r.cnt)
                    begin
                        $error("entry_count: expected %0d, got %0d", exp_r.cnt, entry_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                reply_q.push_back(apply_table_op(func, value, index));
        end
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic send_op(logic [2:0] f, logic signed [DATA_W-1:0] v,
                           logic [IN_IDX_W-1:0] ix);
        int gap;
        start <= 1'b1;
        func  <= f;
        value <= v;
        index <= ix;
        do
            @(posedge clk);
        while (busy);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_empty_table();
        send_op(FUNC_READ_AT, $urandom, 8'd0);
        send_op(FUNC_REMOVE_AT, $urandom, 8'd0);
        send_op(FUNC_REMOVE, 32'sd0, IN_IDX_W'($urandom));
        send_op(FUNC_CONTAINS, VAL_MIN, 8'd255);
    endtask

    task automatic test_fill_to_full();
        int i;
        send_op(FUNC_INSERT, VAL_MAX, 8'd0);
        send_op(FUNC_INSERT, VAL_MIN, 8'd0);
        send_op(FUNC_INSERT, 32'sd0, 8'd0);
        send_op(FUNC_INSERT, -32'sd1, 8'd0);
        send_op(FUNC_INSERT, 32'sd1, 8'd0);
        send_op(FUNC_INSERT, 32'sd0, 8'd0);
        for (i = 6; i < CAPACITY; i++)
            send_op(FUNC_INSERT, $urandom, IN_IDX_W'($urandom));
        send_op(FUNC_INSERT, 32'sd5, 8'd0);
    endtask

    task automatic test_lookup_and_remove();
        send_op(FUNC_READ_AT, 32'sd0, 8'(CAPACITY - 1));
        send_op(FUNC_READ_AT, 32'sd0, 8'(CAPACITY));
        send_op(FUNC_CONTAINS, VAL_MAX, 8'd0);
        send_op(FUNC_REMOVE, 32'sd2, 8'd0);
        send_op(FUNC_REMOVE, 32'sd0, 8'd0);
        send_op(FUNC_REMOVE_AT, 32'sd0, 8'd255);
        send_op(FUNC_UNUSED_LO, VAL_MIN, 8'd255);
        send_op(FUNC_UNUSED_HI, VAL_MAX, 8'd3);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1))
            return pool_vals[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // drift the fill level by changing the insert share every phase
    task automatic test_random_mix(int n_items);
        int i;
        int k;
        int ins_pct;
        int r;
        logic [2:0] f;
        logic [IN_IDX_W-1:0] ix;
        for (i = 0; i < n_items; i++)
        begin
            if (i % 100 == 0)
            begin
                ins_pct = $urandom_range(15, 75);
                gaps_on = ($urandom_range(0, 2) != 0);
                pool_vals[0] = VAL_MIN;
                pool_vals[1] = VAL_MAX;
                pool_vals[2] = 32'sd0;
                pool_vals[3] = -32'sd1;
                for (k = 4; k < 8; k++)
                    pool_vals[k] = $signed($urandom_range(0, 40)) - 32'sd20;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                f = 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
            else if (r < ins_pct + 3)
                f = FUNC_INSERT;
            else
            begin
                case ($urandom_range(0, 3))
                    0:       f = FUNC_REMOVE;
                    1:       f = FUNC_REMOVE_AT;
                    2:       f = FUNC_READ_AT;
                    default: f = FUNC_CONTAINS;
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                ix = IN_IDX_W'($urandom);
            else
                ix = IN_IDX_W'($urandom_range(0, CAPACITY + 1));
            send_op(f, pick_value(), ix);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        tab_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_fill_to_full();
        test_lookup_and_remove();
        test_random_mix(1500);
        start <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Checked %0d result beats: %0d refused as full, %0d bad index, %0d matched.",
                 n_checked, n_full, n_bad_index, n_found);
        $display("Fill level swept between empty and full with the value extremes in play.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
